FILE: hw/rtl/mispd_pkg.sv
// shared types and constants for the multichannel incremental speed pid unit
package mispd_pkg;

  // stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // field widths
  localparam int CH_W    = 2;
  localparam int SPEED_W = 16;
  localparam int ERR_W   = 18;
  localparam int DIFF_W  = 20;
  localparam int GAIN_W  = 16;
  localparam int MAG_W   = 16;
  localparam int DRIVE_W = 17;
  localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W   = 40;
  localparam int SUM_W   = ACC_W + 1;
  localparam int CFG_W   = 64;
  localparam int STEP_W  = $clog2(ACC_W);

  // configuration register indexes
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_KP      = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI      = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD      = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIVISOR = 3'd3;
  localparam logic [IDX_W-1:0] REG_FF      = 3'd4;
  localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] DIVISOR_RESET = 64'h0001_0001_0001_0001;
  localparam logic [MAG_W-1:0] LIMIT_RESET   = 16'd1000;

  // stored direction of a channel
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd3
  } dir_t;

  // what the back end has to do with a sample
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_STOP,
    KIND_RUN
  } kind_t;

  // classified sample passed from front to back
  typedef struct packed {
    logic [CH_W-1:0]          ch;
    kind_t                    kind;
    logic                     rev;
    logic signed [ERR_W-1:0]  err;
  } cmd_t;

  // configuration set seen by the back end
  typedef struct packed {
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] ki;
    logic [CFG_W-1:0] kd;
    logic [CFG_W-1:0] divisor;
    logic [CFG_W-1:0] ff;
    logic [MAG_W-1:0] limit;
  } cfg_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ABS,
    B_DIV,
    B_SUM,
    B_DONE
  } back_state_t;

  // 16-bit lane of a four-lane table
  function automatic logic [GAIN_W-1:0] lane(input logic [CFG_W-1:0] tbl,
                                             input logic [CH_W-1:0] ch);
    lane = tbl[ch*GAIN_W +: GAIN_W];
  endfunction

endpackage

FILE: hw/rtl/mispd_front.sv
// front end: accepts samples, classifies them and computes the aligned error
module mispd_front #(
  parameter int CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel[1:0], set_speed[17:2], measured_speed[33:18], zero fill
  input  logic [mispd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output mispd_pkg::cmd_t                     cmd
);

  logic                                   vld;
  mispd_pkg::cmd_t                        cmd_next;
  logic [mispd_pkg::CH_W-1:0]             ch;
  logic signed [mispd_pkg::SPEED_W-1:0]   target;
  logic signed [mispd_pkg::SPEED_W-1:0]   measured;
  logic signed [mispd_pkg::ERR_W-1:0]     tgt_ext;
  logic signed [mispd_pkg::ERR_W-1:0]     meas_ext;
  logic signed [mispd_pkg::ERR_W-1:0]     mag;
  logic signed [mispd_pkg::ERR_W-1:0]     aligned;

  assign ch       = s_axis_tdata[1:0];
  assign target   = s_axis_tdata[17:2];
  assign measured = s_axis_tdata[33:18];

  // error in the target direction
  always_comb begin
    tgt_ext  = mispd_pkg::ERR_W'(target);
    meas_ext = mispd_pkg::ERR_W'(measured);
    mag      = target[15] ? -tgt_ext : tgt_ext;
    aligned  = target[15] ? -meas_ext : meas_ext;
    cmd_next.ch  = ch;
    cmd_next.rev = target[15];
    cmd_next.err = mag - aligned;
    if (32'(ch) >= CHANNELS) begin
      cmd_next.kind = mispd_pkg::KIND_NONE;
    end else if (target == '0) begin
      cmd_next.kind = mispd_pkg::KIND_STOP;
    end else begin
      cmd_next.kind = mispd_pkg::KIND_RUN;
    end
  end

  assign s_axis_tready = !vld || cmd_ready;
  assign cmd_valid     = vld;

  // holding register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: hw/rtl/mispd_queue.sv
// two-entry queue of classified samples between front and back
module mispd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  mispd_pkg::cmd_t  wr_cmd,
  output logic             rd_valid,
  input  logic             rd_ready,
  output mispd_pkg::cmd_t  rd_cmd
);

  mispd_pkg::cmd_t  mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

endmodule

FILE: hw/rtl/mispd_back.sv
// back end: channel contexts, gain products, serial divider, clamp and result register
module mispd_back #(
  parameter int CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clr_all,
  input  mispd_pkg::cfg_t                   cfg,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  mispd_pkg::cmd_t                   cmd,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_channel[1:0], drive[18:2], zero fill
  output logic [mispd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // channel contexts
  mispd_pkg::dir_t                      prior_dir  [CHANNELS];
  logic signed [mispd_pkg::ERR_W-1:0]   last_err   [CHANNELS];
  logic signed [mispd_pkg::ERR_W-1:0]   older_err  [CHANNELS];
  logic [mispd_pkg::MAG_W-1:0]          drive_mag  [CHANNELS];

  mispd_pkg::back_state_t               state;
  mispd_pkg::back_state_t               state_next;
  mispd_pkg::cmd_t                      cur;
  logic signed [mispd_pkg::ERR_W-1:0]   e1r;
  logic signed [mispd_pkg::ERR_W-1:0]   e2r;
  logic [mispd_pkg::MAG_W-1:0]          held;
  logic [1:0]                           step;
  logic signed [mispd_pkg::PROD_W-1:0]  prod;
  logic signed [mispd_pkg::ACC_W-1:0]   acc;
  logic [mispd_pkg::ACC_W-1:0]          quo;
  logic [mispd_pkg::MAG_W-1:0]          rem;
  logic                                 neg;
  logic [mispd_pkg::STEP_W-1:0]         cnt;
  logic signed [mispd_pkg::SUM_W-1:0]   sum;

  logic                                 pop;
  logic                                 out_free;
  logic                                 finish;
  logic [CW-1:0]                        hidx;
  logic [CW-1:0]                        cidx;
  mispd_pkg::dir_t                      hdir;
  mispd_pkg::dir_t                      cdir;
  logic [mispd_pkg::MAG_W-1:0]          ff_lim;
  logic [mispd_pkg::MAG_W-1:0]          dv;
  logic signed [mispd_pkg::DIFF_W-1:0]  d1;
  logic signed [mispd_pkg::DIFF_W-1:0]  d2;
  logic signed [mispd_pkg::DIFF_W-1:0]  mul_b;
  logic [mispd_pkg::GAIN_W-1:0]         mul_a;
  logic signed [mispd_pkg::PROD_W-1:0]  mul_p;
  logic [mispd_pkg::MAG_W:0]            trial;
  logic                                 ge;
  logic signed [mispd_pkg::SUM_W-1:0]   quo_s;
  logic [mispd_pkg::MAG_W-1:0]          outmag;
  logic signed [mispd_pkg::DRIVE_W-1:0] drive;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mispd_pkg::B_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.kind == mispd_pkg::KIND_RUN) ? mispd_pkg::B_MUL
                                                         : mispd_pkg::B_DONE;
        end
      end
      mispd_pkg::B_MUL: begin
        if (step == 2'd3) begin
          state_next = mispd_pkg::B_ABS;
        end
      end
      mispd_pkg::B_ABS: state_next = mispd_pkg::B_DIV;
      mispd_pkg::B_DIV: begin
        if (cnt == mispd_pkg::STEP_W'(mispd_pkg::ACC_W - 1)) begin
          state_next = mispd_pkg::B_SUM;
        end
      end
      mispd_pkg::B_SUM: state_next = mispd_pkg::B_DONE;
      mispd_pkg::B_DONE: begin
        if (out_free) begin
          state_next = mispd_pkg::B_IDLE;
        end
      end
      default: state_next = mispd_pkg::B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    finish    = 1'b0;
    unique case (state)
      mispd_pkg::B_IDLE: cmd_ready = 1'b1;
      mispd_pkg::B_DONE: finish    = out_free;
      default: begin
        cmd_ready = 1'b0;
        finish    = 1'b0;
      end
    endcase
  end

  assign pop      = cmd_valid && cmd_ready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // context addressing and lane selection
  assign hidx   = CW'(cmd.ch);
  assign cidx   = CW'(cur.ch);
  assign hdir   = cmd.rev ? mispd_pkg::DIR_REV : mispd_pkg::DIR_FWD;
  assign cdir   = cur.rev ? mispd_pkg::DIR_REV : mispd_pkg::DIR_FWD;
  assign ff_lim = (mispd_pkg::lane(cfg.ff, cmd.ch) > cfg.limit) ? cfg.limit
                                                                : mispd_pkg::lane(cfg.ff, cmd.ch);
  assign dv     = (mispd_pkg::lane(cfg.divisor, cur.ch) == '0) ? mispd_pkg::MAG_W'(1)
                                                               : mispd_pkg::lane(cfg.divisor, cur.ch);

  // error differences for the gain products
  assign d1 = mispd_pkg::DIFF_W'(cur.err) - mispd_pkg::DIFF_W'(e1r);
  assign d2 = mispd_pkg::DIFF_W'(cur.err) - (mispd_pkg::DIFF_W'(e1r) <<< 1)
            + mispd_pkg::DIFF_W'(e2r);

  // one shared multiplier, one gain a cycle
  always_comb begin
    case (step)
      2'd0: begin
        mul_a = mispd_pkg::lane(cfg.kp, cur.ch);
        mul_b = d1;
      end
      2'd1: begin
        mul_a = mispd_pkg::lane(cfg.ki, cur.ch);
        mul_b = mispd_pkg::DIFF_W'(cur.err);
      end
      default: begin
        mul_a = mispd_pkg::lane(cfg.kd, cur.ch);
        mul_b = d2;
      end
    endcase
    mul_p = $signed({1'b0, mul_a}) * mul_b;
  end

  // restoring divide step
  assign trial = {rem, quo[mispd_pkg::ACC_W-1]};
  assign ge    = (trial >= {1'b0, dv});

  // delta with its sign restored
  assign quo_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // clamp to 0..limit and apply direction; zero drive unless the sample runs
  always_comb begin
    if (sum < 0) begin
      outmag = '0;
    end else if (sum > $signed({{(mispd_pkg::SUM_W - mispd_pkg::MAG_W){1'b0}}, cfg.limit}))
    begin
      outmag = cfg.limit;
    end else begin
      outmag = sum[mispd_pkg::MAG_W-1:0];
    end
    if (cur.kind != mispd_pkg::KIND_RUN) begin
      drive = '0;
    end else if (cur.rev) begin
      drive = -$signed({1'b0, outmag});
    end else begin
      drive = $signed({1'b0, outmag});
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mispd_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mispd_pkg::B_IDLE: begin
        if (pop) begin
          cur  <= cmd;
          step <= 2'd0;
          if (cmd.kind == mispd_pkg::KIND_RUN) begin
            if (prior_dir[hidx] != hdir) begin
              e1r  <= '0;
              e2r  <= '0;
              held <= ff_lim;
            end else begin
              e1r  <= last_err[hidx];
              e2r  <= older_err[hidx];
              held <= drive_mag[hidx];
            end
          end
        end
      end
      mispd_pkg::B_MUL: begin
        prod <= mul_p;
        acc  <= (step == 2'd0) ? '0 : acc + mispd_pkg::ACC_W'(prod);
        step <= step + 2'd1;
      end
      mispd_pkg::B_ABS: begin
        neg <= acc[mispd_pkg::ACC_W-1];
        quo <= acc[mispd_pkg::ACC_W-1] ? mispd_pkg::ACC_W'(-acc) : mispd_pkg::ACC_W'(acc);
        rem <= '0;
        cnt <= '0;
      end
      mispd_pkg::B_DIV: begin
        quo <= {quo[mispd_pkg::ACC_W-2:0], ge};
        rem <= ge ? mispd_pkg::MAG_W'(trial - {1'b0, dv}) : trial[mispd_pkg::MAG_W-1:0];
        cnt <= cnt + mispd_pkg::STEP_W'(1);
      end
      mispd_pkg::B_SUM: begin
        sum <= $signed({{(mispd_pkg::SUM_W - mispd_pkg::MAG_W){1'b0}}, held}) + quo_s;
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // channel context updates, cleared by reset and by any write to a known register index
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prior_dir[c] <= mispd_pkg::DIR_STOP;
        last_err[c]  <= '0;
        older_err[c] <= '0;
        drive_mag[c] <= '0;
      end
    end else if (finish) begin
      if (cur.kind == mispd_pkg::KIND_STOP) begin
        prior_dir[cidx] <= mispd_pkg::DIR_STOP;
        last_err[cidx]  <= '0;
        older_err[cidx] <= '0;
        drive_mag[cidx] <= '0;
      end else if (cur.kind == mispd_pkg::KIND_RUN) begin
        prior_dir[cidx] <= cdir;
        last_err[cidx]  <= cur.err;
        older_err[cidx] <= e1r;
        drive_mag[cidx] <= outmag;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= {5'b0, drive, cur.ch};
    end
  end

endmodule

FILE: hw/rtl/multichannel_incremental_speed_pid_unit.sv
// top level: register file, front end, queue and back end of the speed pid unit
// a running sample passes the back-end steps in order: context load, gain multiplies on a
// shared multiplier, abs, serial divide, add, clamp; stop and out-of-range samples go
// straight to the result; the back end takes a new sample only once the last result is
// handed over; the front end and queue take up to three samples while the back is busy
// synchronous reset clears all channel contexts and loads the register defaults
module multichannel_incremental_speed_pid_unit #(
  parameter int CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // channel[1:0], set_speed[17:2], measured_speed[33:18], zero fill
  input  logic [mispd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_channel[1:0], drive[18:2], zero fill
  output logic [mispd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mispd_pkg::IDX_W-1:0]       cfg_index,
  input  logic [mispd_pkg::CFG_W-1:0]       cfg_data
);

  mispd_pkg::cfg_t  cfg;
  logic             cfg_hit;
  logic             clr_all;
  logic             f_valid;
  logic             f_ready;
  mispd_pkg::cmd_t  f_cmd;
  logic             q_valid;
  logic             q_ready;
  mispd_pkg::cmd_t  q_cmd;

  assign cfg_ready = 1'b1;

  // index decode
  always_comb begin
    unique case (cfg_index)
      mispd_pkg::REG_KP, mispd_pkg::REG_KI, mispd_pkg::REG_KD,
      mispd_pkg::REG_DIVISOR, mispd_pkg::REG_FF, mispd_pkg::REG_LIMIT: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign clr_all = cfg_valid && cfg_ready && cfg_hit;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp      <= '0;
      cfg.ki      <= '0;
      cfg.kd      <= '0;
      cfg.divisor <= mispd_pkg::DIVISOR_RESET;
      cfg.ff      <= '0;
      cfg.limit   <= mispd_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mispd_pkg::REG_KP:      cfg.kp      <= cfg_data;
        mispd_pkg::REG_KI:      cfg.ki      <= cfg_data;
        mispd_pkg::REG_KD:      cfg.kd      <= cfg_data;
        mispd_pkg::REG_DIVISOR: cfg.divisor <= cfg_data;
        mispd_pkg::REG_FF:      cfg.ff      <= cfg_data;
        mispd_pkg::REG_LIMIT:   cfg.limit   <= cfg_data[mispd_pkg::MAG_W-1:0];
        default:                cfg.limit   <= cfg.limit;
      endcase
    end
  end

  mispd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  mispd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  mispd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .clr_all       (clr_all),
    .cfg           (cfg),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: tb/multichannel_incremental_speed_pid_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the multichannel incremental speed pid unit
module multichannel_incremental_speed_pid_unit_tb;
  import mispd_pkg::*;

  // register indexes past the end of the register list
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int NUM_CH       = 4;
  localparam int BURST_MAX    = 18;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [CH_W-1:0]    ch;
    logic [DRIVE_W-1:0] drive;
  } drive_result_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
  } reg_write_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // channel, set_speed, measured_speed, zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // out_channel, drive, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index     = '0;
  logic [CFG_W-1:0]       cfg_data      = '0;

  // register copy and per-channel loop context of the predictor
  logic [CFG_W-1:0] kp_tbl, ki_tbl, kd_tbl, div_tbl, ff_tbl;
  logic [MAG_W-1:0] drive_limit;
  dir_t             ctx_dir [NUM_CH];
  longint           ctx_e1  [NUM_CH];
  longint           ctx_e2  [NUM_CH];
  longint           ctx_mag [NUM_CH];

  drive_result_t drive_queue [$];
  reg_write_t    reg_plan [$];
  int            set_point [NUM_CH];

  // idle control of both stream sides, quiet shared by the two
  bit quiet      = 1'b0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;

  int fail_count     = 0;
  int samples_sent   = 0;
  int drives_checked = 0;
  int reg_writes     = 0;
  int starts_seen    = 0;
  int stops_seen     = 0;
  int limit_hits     = 0;

  multichannel_incremental_speed_pid_unit #(
    .CHANNELS(NUM_CH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop for a hung run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint table_lane(input logic [CFG_W-1:0] tbl,
                                        input logic [CH_W-1:0] ch);
    return longint'(tbl[ch*GAIN_W +: GAIN_W]);
  endfunction

  function automatic longint clamp_to_limit(input longint v);
    longint lim;
    lim = longint'(drive_limit);
    if (v > lim) return lim;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic void clear_context(input int ch);
    ctx_dir[ch] = DIR_STOP;
    ctx_e1[ch]  = 0;
    ctx_e2[ch]  = 0;
    ctx_mag[ch] = 0;
  endfunction

  function automatic void clear_all_contexts();
    for (int c = 0; c < NUM_CH; c++) clear_context(c);
  endfunction

  function automatic void reset_model();
    kp_tbl      = '0;
    ki_tbl      = '0;
    kd_tbl      = '0;
    div_tbl     = DIVISOR_RESET;
    ff_tbl      = '0;
    drive_limit = LIMIT_RESET;
    clear_all_contexts();
  endfunction

  // a write to a known register clears every channel, others are dropped
  function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] value);
    case (idx)
      REG_KP:      kp_tbl = value;
      REG_KI:      ki_tbl = value;
      REG_KD:      kd_tbl = value;
      REG_DIVISOR: div_tbl = value;
      REG_FF:      ff_tbl = value;
      REG_LIMIT:   drive_limit = value[MAG_W-1:0];
      default:     return;
    endcase
    clear_all_contexts();
  endfunction

  // incremental pid step for one sample, returns the signed drive
  function automatic logic [DRIVE_W-1:0] predict_drive(input logic [CH_W-1:0] ch,
      input logic signed [SPEED_W-1:0] tgt, input logic signed [SPEED_W-1:0] meas);
    longint t, m, mag, aligned, err, e1, e2, div, delta, outmag;
    dir_t want_dir;
    logic [DRIVE_W-1:0] drv;
    t = longint'(tgt);
    m = longint'(meas);
    // zero target stops the loop
    if (t == 0) begin
      clear_context(ch);
      stops_seen++;
      return '0;
    end
    want_dir = (t < 0) ? DIR_REV : DIR_FWD;
    // start or reversal: fresh context preset to the feedforward magnitude
    if (ctx_dir[ch] != want_dir) begin
      clear_context(ch);
      ctx_mag[ch] = clamp_to_limit(table_lane(ff_tbl, ch));
      starts_seen++;
    end
    ctx_dir[ch] = want_dir;
    mag     = (t < 0) ? -t : t;
    aligned = (t < 0) ? -m : m;
    err     = mag - aligned;
    e1      = ctx_e1[ch];
    e2      = ctx_e2[ch];
    div     = table_lane(div_tbl, ch);
    if (div == 0) div = 1;
    delta = table_lane(kp_tbl, ch) * (err - e1)
          + table_lane(ki_tbl, ch) * err
          + table_lane(kd_tbl, ch) * (err - 2 * e1 + e2);
    // signed division truncates toward zero
    delta  = delta / div;
    outmag = clamp_to_limit(ctx_mag[ch] + delta);
    if (outmag != 0 && outmag == longint'(drive_limit)) limit_hits++;
    ctx_mag[ch] = outmag;
    ctx_e2[ch]  = e1;
    ctx_e1[ch]  = err;
    drv = DRIVE_W'((t < 0) ? -outmag : outmag);
    return drv;
  endfunction

  // ---------------------------------------------------------------- result side

  // compare each result transfer, then pick the next ready level
  always @(posedge clk) begin : result_check
    drive_result_t       want;
    logic [CH_W-1:0]     got_ch;
    logic [DRIVE_W-1:0]  got_drive;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_ch    = m_axis_tdata[CH_W-1:0];
      got_drive = m_axis_tdata[CH_W +: DRIVE_W];
      if (drive_queue.size() == 0) begin
        $error("unexpected result transfer: out_channel %0d drive %0d",
               got_ch, $signed(got_drive));
        fail_count++;
      end else begin
        want = drive_queue.pop_front();
        drives_checked++;
        if (got_ch !== want.ch) begin
          $error("out_channel: expected %0d actual %0d", want.ch, got_ch);
          fail_count++;
        end
        if (got_drive !== want.drive) begin
          $error("drive: expected %0d actual %0d",
                 $signed(want.drive), $signed(got_drive));
          fail_count++;
        end
      end
    end
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, BURST_MAX - 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus side

  // one sample transfer, with an optional idle burst ahead of it
  task automatic send_sample(input logic [CH_W-1:0] ch,
                             input logic signed [SPEED_W-1:0] tgt,
                             input logic signed [SPEED_W-1:0] meas);
    drive_result_t want;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - CH_W - 2*SPEED_W){1'b0}}, meas, tgt, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want.ch    = ch;
    want.drive = predict_drive(ch, tgt, meas);
    drive_queue.push_back(want);
    samples_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
  endtask

  function automatic void plan_write(input logic [IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_plan.push_back(w);
  endfunction

  // write the planned registers back to back while the unit is idle
  task automatic commit_registers();
    reg_write_t w;
    wait_drained();
    while (reg_plan.size() != 0) begin
      w = reg_plan.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_register(w.idx, w.data);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pack_lanes(input int l3, input int l2,
                                                  input int l1, input int l0);
    return {16'(l3), 16'(l2), 16'(l1), 16'(l0)};
  endfunction

  function automatic logic [GAIN_W-1:0] pick_lane(input bit is_divisor);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return is_divisor ? GAIN_W'($urandom_range(1, 16))
                                 : GAIN_W'($urandom_range(1, 8));
      3:       return is_divisor ? GAIN_W'($urandom_range(16, 4096))
                                 : GAIN_W'($urandom_range(1, 255));
      4:       return is_divisor ? GAIN_W'($urandom_range(256, 65535))
                                 : GAIN_W'($urandom_range(1, 64));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // random gains, divisors, feedforward and limit
  function automatic void plan_random_settings();
    logic [CFG_W-1:0] tbl [5];
    logic [MAG_W-1:0] lim;
    for (int r = 0; r < 5; r++)
      for (int l = 0; l < NUM_CH; l++) tbl[r][l*GAIN_W +: GAIN_W] = pick_lane(r == 3);
    case ($urandom_range(0, 5))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = LIMIT_RESET;
      3:       lim = MAG_W'($urandom_range(1, 200));
      default: lim = MAG_W'($urandom);
    endcase
    plan_write(REG_KP, tbl[0]);
    plan_write(REG_KI, tbl[1]);
    plan_write(REG_KD, tbl[2]);
    plan_write(REG_DIVISOR, tbl[3]);
    plan_write(REG_FF, tbl[4]);
    plan_write(REG_LIMIT, {$urandom, 16'($urandom), lim});
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 25;
      default: return 60;
    endcase
  endfunction

  function automatic int pick_set_point();
    int m;
    case ($urandom_range(0, 3))
      0:       m = $urandom_range(1, 100);
      1:       m = $urandom_range(100, 3000);
      2:       m = $urandom_range(1, 32767);
      default: m = 32767;
    endcase
    if ($urandom_range(0, 1) == 0) return m;
    return (m == 32767 && $urandom_range(0, 1) == 0) ? -32768 : -m;
  endfunction

  // mostly steady loops near the set point, some stops and raw noise
  task automatic send_random_sample();
    int ch, meas;
    ch = $urandom_range(0, NUM_CH - 1);
    case ($urandom_range(0, 19))
      0, 1:    send_sample(CH_W'(ch), 16'sd0, SPEED_W'($urandom));
      2, 3, 4: send_sample(CH_W'(ch), SPEED_W'($urandom), SPEED_W'($urandom));
      default: begin
        if (set_point[ch] == 0 || $urandom_range(0, 7) == 0) set_point[ch] = pick_set_point();
        meas = set_point[ch] + int'($urandom_range(0, 200)) - 100;
        if (meas > 32767) meas = 32767;
        if (meas < -32768) meas = -32768;
        send_sample(CH_W'(ch), SPEED_W'(set_point[ch]), SPEED_W'(meas));
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  // default registers: all gains zero, no feedforward, so every drive is zero
  task automatic test_reset_defaults();
    send_sample(2'd0, 16'sd100, 16'sd0);
    send_sample(2'd1, -16'sd32768, 16'sd32767);
    send_sample(2'd2, 16'sd0, -16'sd5);
    send_sample(2'd3, 16'sd32767, -16'sd32768);
  endtask

  // start, steady, reversal, stop, zero divisor lane and field extremes
  task automatic test_directed_cases();
    gap_pct   = 25;
    stall_pct = 25;
    plan_write(REG_KP, pack_lanes(65535, 4, 1, 2));
    plan_write(REG_KI, pack_lanes(65535, 0, 1, 1));
    plan_write(REG_KD, pack_lanes(65535, 2, 0, 1));
    plan_write(REG_DIVISOR, pack_lanes(1, 0, 3, 2));
    plan_write(REG_FF, pack_lanes(0, 300, 0, 800));
    plan_write(REG_LIMIT, 64'd500);
    commit_registers();
    // feedforward above the limit gets clamped on start
    send_sample(2'd0, 16'sd100, 16'sd0);
    send_sample(2'd0, 16'sd100, 16'sd100);
    send_sample(2'd0, -16'sd100, 16'sd0);
    send_sample(2'd0, 16'sd0, 16'sd5);
    send_sample(2'd1, -16'sd50, -16'sd40);
    // zero divisor lane divides by one
    send_sample(2'd2, 16'sd200, 16'sd150);
    send_sample(2'd2, 16'sd200, 16'sd250);
    // saturate upward, then downward, then reverse at full scale
    send_sample(2'd3, 16'sd32767, -16'sd32768);
    send_sample(2'd3, 16'sd32767, 16'sd32767);
    send_sample(2'd3, -16'sd32768, 16'sd32767);
    send_sample(2'd3, -16'sd32768, -16'sd32768);
    send_sample(2'd1, 16'sd1, -16'sd1);
  endtask

  // writes past the register list change nothing and keep the contexts
  task automatic test_spare_registers();
    plan_write(REG_SPARE_LO, {$urandom, $urandom});
    plan_write(REG_SPARE_HI, {$urandom, $urandom});
    commit_registers();
    send_sample(2'd1, 16'sd1, 16'sd0);
  endtask

  // zero limit pins every drive at zero, full limit allows the widest drive
  task automatic test_limit_extremes();
    plan_write(REG_LIMIT, {48'hffff_ffff_ffff, 16'd0});
    commit_registers();
    send_sample(2'd0, 16'sd500, 16'sd0);
    send_sample(2'd2, -16'sd500, 16'sd0);
    plan_write(REG_KP, '1);
    plan_write(REG_KI, '1);
    plan_write(REG_KD, '1);
    plan_write(REG_DIVISOR, '0);
    plan_write(REG_FF, '1);
    plan_write(REG_LIMIT, 64'hffff);
    commit_registers();
    send_sample(2'd1, 16'sd32767, -16'sd32768);
    send_sample(2'd1, -16'sd32768, 16'sd32767);
    send_sample(2'd1, -16'sd32768, -16'sd32768);
  endtask

  // several random register settings, each with its own idle mix
  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      plan_random_settings();
      commit_registers();
      gap_pct   = pick_idle_pct();
      stall_pct = pick_idle_pct();
      repeat (per_phase) send_random_sample();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail(input int count);
    plan_random_settings();
    commit_registers();
    quiet     = 1'b1;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (count) send_random_sample();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_model();
    foreach (set_point[c]) set_point[c] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_cases();
    test_spare_registers();
    test_limit_extremes();
    test_random_settings(6, 170);
    test_full_rate_tail(200);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples, %0d register writes, %0d drive values compared",
             samples_sent, reg_writes, drives_checked);
    $display("loop events: %0d starts or reversals, %0d stops, %0d drives at the limit",
             starts_seen, stops_seen, limit_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mispd_pkg.sv
hw/rtl/mispd_front.sv
hw/rtl/mispd_queue.sv
hw/rtl/mispd_back.sv
hw/rtl/multichannel_incremental_speed_pid_unit.sv
tb/multichannel_incremental_speed_pid_unit_tb.sv
